/* rtl/core/tpf_pkg.sv */
// tpf_pkg: shared types and constants of the touch point filter and mapper
// holds the request and result structs, configuration struct and register indexes
// no dependencies
`timescale 1ns / 1ps

package tpf_pkg;

  localparam int FINGER_W  = 8;
  localparam int COORD_W   = 12;
  localparam int LIMIT_W   = 13;
  localparam int WRAP_W    = 16;
  localparam int INDEX_W   = 3;
  localparam int CFG_W     = 13;

  localparam logic [COORD_W-1:0] SIZE_RESET  = 12'd240;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd240;

  // motion thresholds of the axis lock
  localparam logic [COORD_W:0] LOCK_MIN  = 13'd3;
  localparam logic [COORD_W:0] LOCK_BIAS = 13'd6;

  typedef enum logic [INDEX_W-1:0] {
    REG_DISPLAY_WIDTH  = 3'd0,
    REG_DISPLAY_HEIGHT = 3'd1,
    REG_ROTATION       = 3'd2,
    REG_SWAP_AXES      = 3'd3,
    REG_INVERT_H       = 3'd4,
    REG_INVERT_V       = 3'd5,
    REG_SANITY_LIMIT   = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rotation_t;

  typedef struct packed {
    logic [FINGER_W-1:0] s0_fingers;
    logic [COORD_W-1:0]  s0_x;
    logic [COORD_W-1:0]  s0_y;
    logic [FINGER_W-1:0] s1_fingers;
    logic [COORD_W-1:0]  s1_x;
    logic [COORD_W-1:0]  s1_y;
    logic [FINGER_W-1:0] s2_fingers;
    logic [COORD_W-1:0]  s2_x;
    logic [COORD_W-1:0]  s2_y;
  } sample_t;

  typedef struct packed {
    logic               touched;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
  } point_t;

  typedef struct packed {
    logic [COORD_W-1:0] display_width;
    logic [COORD_W-1:0] display_height;
    rotation_t          rotation;
    logic               swap_axes;
    logic               invert_horizontal;
    logic               invert_vertical;
    logic [LIMIT_W-1:0] sanity_limit;
  } cfg_t;

endpackage

/* rtl/core/tpf_median.sv */
// tpf_median: reading validation and per-axis median of up to three readings
// depends on tpf_pkg
`timescale 1ns / 1ps

module tpf_median
  import tpf_pkg::*;
(
  input  sample_t            sample,
  input  logic [LIMIT_W-1:0] sanity_limit,
  output point_t             filtered
);

  logic [2:0] ok;

  function automatic logic [COORD_W-1:0] max2(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [COORD_W-1:0] min2(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // element n/2 of the sorted valid values: the one, the larger of two, or the median
  function automatic logic [COORD_W-1:0] pick(logic [2:0] v, logic [COORD_W-1:0] a,
                                              logic [COORD_W-1:0] b, logic [COORD_W-1:0] c);
    logic [COORD_W-1:0] res;
    case (v)
      3'b111:  res = max2(min2(a, b), min2(max2(a, b), c));
      3'b011:  res = max2(a, b);
      3'b101:  res = max2(a, c);
      3'b110:  res = max2(b, c);
      3'b001:  res = a;
      3'b010:  res = b;
      3'b100:  res = c;
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic logic good(logic [FINGER_W-1:0] f, logic [COORD_W-1:0] x,
                                logic [COORD_W-1:0] y, logic [LIMIT_W-1:0] lim);
    return (f != '0) && ({1'b0, x} < lim) && ({1'b0, y} < lim);
  endfunction

  always_comb begin
    ok[0] = good(sample.s0_fingers, sample.s0_x, sample.s0_y, sanity_limit);
    ok[1] = good(sample.s1_fingers, sample.s1_x, sample.s1_y, sanity_limit);
    ok[2] = good(sample.s2_fingers, sample.s2_x, sample.s2_y, sanity_limit);
    filtered.touched = |ok;
    filtered.point_x = pick(ok, sample.s0_x, sample.s1_x, sample.s2_x);
    filtered.point_y = pick(ok, sample.s0_y, sample.s1_y, sample.s2_y);
  end

endmodule

/* rtl/core/tpf_map.sv */
// tpf_map: rotation, axis swap, inversion and clamp to the display
// depends on tpf_pkg
`timescale 1ns / 1ps

module tpf_map
  import tpf_pkg::*;
(
  input  point_t raw,
  input  cfg_t   cfg,
  output point_t mapped
);

  logic [WRAP_W-1:0] w16, h16, wm1, hm1, x16, y16;
  logic [WRAP_W-1:0] rx, ry, sx, sy, ix, iy;

  always_comb begin
    w16 = {{(WRAP_W-COORD_W){1'b0}}, cfg.display_width};
    h16 = {{(WRAP_W-COORD_W){1'b0}}, cfg.display_height};
    wm1 = w16 - WRAP_W'(1);
    hm1 = h16 - WRAP_W'(1);
    x16 = {{(WRAP_W-COORD_W){1'b0}}, raw.point_x};
    y16 = {{(WRAP_W-COORD_W){1'b0}}, raw.point_y};

    // differences wrap at 16 bits, the clamp catches the wrapped values
    case (cfg.rotation)
      ROT_90:  begin rx = hm1 - y16; ry = x16;       end
      ROT_180: begin rx = wm1 - x16; ry = hm1 - y16; end
      ROT_270: begin rx = y16;       ry = wm1 - x16; end
      default: begin rx = x16;       ry = y16;       end
    endcase

    sx = cfg.swap_axes ? ry : rx;
    sy = cfg.swap_axes ? rx : ry;
    ix = cfg.invert_horizontal ? wm1 - sx : sx;
    iy = cfg.invert_vertical   ? hm1 - sy : sy;

    mapped.touched = raw.touched;
    if (cfg.display_width == '0) begin
      mapped.point_x = '0;
    end else if (ix >= w16) begin
      mapped.point_x = wm1[COORD_W-1:0];
    end else begin
      mapped.point_x = ix[COORD_W-1:0];
    end
    if (cfg.display_height == '0) begin
      mapped.point_y = '0;
    end else if (iy >= h16) begin
      mapped.point_y = hm1[COORD_W-1:0];
    end else begin
      mapped.point_y = iy[COORD_W-1:0];
    end
  end

endmodule

/* rtl/core/tpf_lock.sv */
// tpf_lock: axis lock against the previous point, zero result when untouched
// depends on tpf_pkg
`timescale 1ns / 1ps

module tpf_lock
  import tpf_pkg::*;
(
  input  point_t             mapped,
  input  logic [COORD_W-1:0] prev_x,
  input  logic [COORD_W-1:0] prev_y,
  output point_t             locked
);

  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W:0]        adx, ady;
  logic                    moving;

  always_comb begin
    dx = $signed({1'b0, mapped.point_x}) - $signed({1'b0, prev_x});
    dy = $signed({1'b0, mapped.point_y}) - $signed({1'b0, prev_y});
    adx = dx[COORD_W] ? $unsigned(-dx) : $unsigned(dx);
    ady = dy[COORD_W] ? $unsigned(-dy) : $unsigned(dy);
    moving = (adx > LOCK_MIN) || (ady > LOCK_MIN);

    locked = mapped;
    if (!mapped.touched) begin
      locked.point_x = '0;
      locked.point_y = '0;
    end else if (moving && (ady > adx + LOCK_BIAS)) begin
      locked.point_x = prev_x;
    end else if (moving && (adx > ady + LOCK_BIAS)) begin
      locked.point_y = prev_y;
    end
  end

endmodule

/* rtl/core/touch_point_filter_mapper.sv */
// touch_point_filter_mapper: top level, request and result registers, config, point state
// depends on tpf_pkg, tpf_median, tpf_map, tpf_lock
//
//   port group   | handshake                   | payload
//   -------------+-----------------------------+---------------------------
//   sample       | sample_valid / sample_stall | sample_data (sample_t)
//   point        | point_valid / point_stall   | point_data (point_t)
//   cfg          | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// one request per cycle while the result side does not stall; a request waits in the request register,
// the filter, map and lock logic sit between it and the result register
// point_valid rises when the request moves on from the request register into the result register
// rst clears valids, config to its defaults and the previous point to zero
// a stalled result holds the request register, which then stalls the sample side
`timescale 1ns / 1ps

module touch_point_filter_mapper
  import tpf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  sample_t             sample_data,
  output logic                point_valid,
  input  logic                point_stall,
  output point_t              point_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [INDEX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  cfg_t               cfg;
  sample_t            hold;
  logic               hold_valid;
  logic               advance;
  logic [COORD_W-1:0] prev_x, prev_y;
  point_t             filtered, mapped, result;

  assign cfg_ready    = 1'b1;
  assign advance      = hold_valid && (!point_valid || !point_stall);
  assign sample_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.display_width     <= SIZE_RESET;
      cfg.display_height    <= SIZE_RESET;
      cfg.rotation          <= ROT_0;
      cfg.swap_axes         <= 1'b0;
      cfg.invert_horizontal <= 1'b0;
      cfg.invert_vertical   <= 1'b0;
      cfg.sanity_limit      <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_DISPLAY_WIDTH:  cfg.display_width     <= cfg_data[COORD_W-1:0];
        REG_DISPLAY_HEIGHT: cfg.display_height    <= cfg_data[COORD_W-1:0];
        REG_ROTATION:       cfg.rotation          <= rotation_t'(cfg_data[1:0]);
        REG_SWAP_AXES:      cfg.swap_axes         <= cfg_data[0];
        REG_INVERT_H:       cfg.invert_horizontal <= cfg_data[0];
        REG_INVERT_V:       cfg.invert_vertical   <= cfg_data[0];
        REG_SANITY_LIMIT:   cfg.sanity_limit      <= cfg_data[LIMIT_W-1:0];
        default:            ;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (sample_valid && !sample_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      hold <= sample_data;
    end
  end

  tpf_median u_median (
    .sample       (hold),
    .sanity_limit (cfg.sanity_limit),
    .filtered     (filtered)
  );

  tpf_map u_map (
    .raw    (filtered),
    .cfg    (cfg),
    .mapped (mapped)
  );

  tpf_lock u_lock (
    .mapped (mapped),
    .prev_x (prev_x),
    .prev_y (prev_y),
    .locked (result)
  );

  // result register and point state move together, the point state only on touched results
  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
      prev_x      <= '0;
      prev_y      <= '0;
    end else if (advance) begin
      point_valid <= 1'b1;
      if (result.touched) begin
        prev_x <= result.point_x;
        prev_y <= result.point_y;
      end
    end else if (!point_stall) begin
      point_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      point_data <= result;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (point_valid && !point_data.touched) |->
      (point_data.point_x == '0 && point_data.point_y == '0))
    else $error("untouched result carries a nonzero point");

  assert property (@(posedge clk) disable iff (rst)
    (advance && !result.touched) |=> ($stable(prev_x) && $stable(prev_y)))
    else $error("point state changed on an untouched request");

  assert property (@(posedge clk) disable iff (rst)
    (advance && result.touched) |=>
      (prev_x == point_data.point_x && prev_y == point_data.point_y))
    else $error("point state differs from the last touched result");

  assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !advance) |=> (hold_valid && $stable(hold)))
    else $error("held request lost while the result side stalled");

endmodule

/* bench/tb_top.sv */
// tb_top: self-checking bench for touch_point_filter_mapper
// predicts each point from the three raw readings and compares it with the block output
// depends on tpf_pkg and the touch_point_filter_mapper rtl
`timescale 1ns / 1ps

module tb_top;
  import tpf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               sample_valid = 1'b0;
  logic               sample_stall;
  sample_t            sample_data = '0;
  logic               point_valid;
  logic               point_stall = 1'b0;
  point_t             point_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  touch_point_filter_mapper dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_data  (sample_data),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point_data   (point_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // bench copy of the mapping setup and the filter state
  logic [COORD_W-1:0] map_width  = SIZE_RESET;
  logic [COORD_W-1:0] map_height = SIZE_RESET;
  rotation_t          map_rot    = ROT_0;
  logic               map_swap   = 1'b0;
  logic               map_inv_h  = 1'b0;
  logic               map_inv_v  = 1'b0;
  logic [LIMIT_W-1:0] map_limit  = LIMIT_RESET;
  logic [COORD_W-1:0] last_x     = '0;
  logic [COORD_W-1:0] last_y     = '0;

  sample_t touch_queue[$];
  point_t  point_expect_q[$];

  int send_idle_pct = 30;
  int stall_pct     = 47;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int walk_x        = 0;
  int walk_y        = 0;
  int cycles        = 0;
  int requests      = 0;
  int points_seen   = 0;
  int untouched     = 0;
  int setups        = 1;
  int errors        = 0;

  function automatic logic [15:0] clamp_to(logic [15:0] v, logic [COORD_W-1:0] size);
    if (size == 0) return 16'd0;
    if (v >= {4'd0, size}) return {4'd0, size} - 16'd1;
    return v;
  endfunction

  // median filter, rotation, swap, inversion, clamp and axis lock
  function automatic point_t predict_point(sample_t s);
    logic [FINGER_W-1:0] fing [3];
    logic [COORD_W-1:0]  rx [3];
    logic [COORD_W-1:0]  ry [3];
    logic [COORD_W-1:0]  xs [3];
    logic [COORD_W-1:0]  ys [3];
    logic [COORD_W-1:0]  t;
    logic [15:0]         x, y, nx, ny, w, h;
    int                  n, i, j, xi, yi, adx, ady;
    point_t              p;
    fing[0] = s.s0_fingers; rx[0] = s.s0_x; ry[0] = s.s0_y;
    fing[1] = s.s1_fingers; rx[1] = s.s1_x; ry[1] = s.s1_y;
    fing[2] = s.s2_fingers; rx[2] = s.s2_x; ry[2] = s.s2_y;
    n = 0;
    for (i = 0; i < 3; i++) begin
      if (fing[i] != 0 && {1'b0, rx[i]} < map_limit && {1'b0, ry[i]} < map_limit) begin
        xs[n] = rx[i];
        ys[n] = ry[i];
        n++;
      end
    end
    if (n == 0) return '0;
    for (i = 0; i < n; i++) begin
      for (j = i + 1; j < n; j++) begin
        if (xs[j] < xs[i]) begin
          t = xs[i]; xs[i] = xs[j]; xs[j] = t;
        end
        if (ys[j] < ys[i]) begin
          t = ys[i]; ys[i] = ys[j]; ys[j] = t;
        end
      end
    end
    x = {4'd0, xs[n/2]};
    y = {4'd0, ys[n/2]};
    w = {4'd0, map_width};
    h = {4'd0, map_height};
    case (map_rot)
      ROT_90: begin
        nx = h - 16'd1 - y; ny = x;
      end
      ROT_180: begin
        nx = w - 16'd1 - x; ny = h - 16'd1 - y;
      end
      ROT_270: begin
        nx = y; ny = w - 16'd1 - x;
      end
      default: begin
        nx = x; ny = y;
      end
    endcase
    if (map_swap) begin
      x = ny; y = nx;
    end else begin
      x = nx; y = ny;
    end
    if (map_inv_h) x = w - 16'd1 - x;
    if (map_inv_v) y = h - 16'd1 - y;
    xi = int'(clamp_to(x, map_width));
    yi = int'(clamp_to(y, map_height));
    adx = xi - int'(last_x);
    ady = yi - int'(last_y);
    if (adx < 0) adx = -adx;
    if (ady < 0) ady = -ady;
    if (adx > int'(LOCK_MIN) || ady > int'(LOCK_MIN)) begin
      if (ady > adx + int'(LOCK_BIAS)) xi = int'(last_x);
      else if (adx > ady + int'(LOCK_BIAS)) yi = int'(last_y);
    end
    last_x = xi[COORD_W-1:0];
    last_y = yi[COORD_W-1:0];
    p.touched = 1'b1;
    p.point_x = last_x;
    p.point_y = last_y;
    return p;
  endfunction

  function automatic sample_t reading3(int f0, int x0, int y0, int f1, int x1, int y1,
                                        int f2, int x2, int y2);
    sample_t s;
    s.s0_fingers = FINGER_W'(f0); s.s0_x = COORD_W'(x0); s.s0_y = COORD_W'(y0);
    s.s1_fingers = FINGER_W'(f1); s.s1_x = COORD_W'(x1); s.s1_y = COORD_W'(y1);
    s.s2_fingers = FINGER_W'(f2); s.s2_x = COORD_W'(x2); s.s2_y = COORD_W'(y2);
    return s;
  endfunction

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int edge_coord(int lim);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return clip(lim - 1, 0, 4095);
      2: return clip(lim, 0, 4095);
      default: return 4095;
    endcase
  endfunction

  // mostly a wandering finger with jitter, some garbage and some boundary readings
  function automatic sample_t random_touch();
    logic [FINGER_W-1:0] f [3];
    logic [COORD_W-1:0]  xv [3];
    logic [COORD_W-1:0]  yv [3];
    int lim, kind, i, j, k, cx, cy;
    lim = (map_limit > 4096) ? 4096 : ((map_limit == 0) ? 1 : int'(map_limit));
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      j = $urandom_range(0, 80);
      case ($urandom_range(0, 9))
        0: begin
          walk_x = $urandom_range(0, lim - 1);
          walk_y = $urandom_range(0, lim - 1);
        end
        1, 2: walk_x = walk_x + j - 40;
        3, 4: walk_y = walk_y + j - 40;
        default: begin
          j = $urandom_range(0, 6);
          k = $urandom_range(0, 6);
          walk_x = walk_x + j - 3;
          walk_y = walk_y + k - 3;
        end
      endcase
      walk_x = clip(walk_x, 0, lim - 1);
      walk_y = clip(walk_y, 0, lim - 1);
    end
    for (i = 0; i < 3; i++) begin
      if (kind < 70) begin
        f[i] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 5));
        j = $urandom_range(0, 4);
        k = $urandom_range(0, 4);
        cx = clip(walk_x + j - 2, 0, lim - 1);
        cy = clip(walk_y + k - 2, 0, lim - 1);
        // an occasional dropped or out of range reading
        if ($urandom_range(0, 99) < 12) begin
          case ($urandom_range(0, 2))
            0: f[i] = '0;
            1: cx = $urandom_range(clip(lim, 0, 4095), 4095);
            default: cy = $urandom_range(clip(lim, 0, 4095), 4095);
          endcase
        end
        xv[i] = COORD_W'(cx);
        yv[i] = COORD_W'(cy);
      end else if (kind < 85) begin
        f[i] = FINGER_W'($urandom);
        xv[i] = COORD_W'($urandom);
        yv[i] = COORD_W'($urandom);
      end else begin
        f[i] = $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
        xv[i] = COORD_W'(edge_coord(lim));
        yv[i] = COORD_W'(edge_coord(lim));
      end
    end
    return reading3(f[0], xv[0], yv[0], f[1], xv[1], yv[1], f[2], xv[2], yv[2]);
  endfunction

  task automatic check_point(point_t got);
    point_t want;
    points_seen++;
    if (!got.touched) untouched++;
    if (point_expect_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected point: touched=%0d x=%0d y=%0d",
                                 got.touched, got.point_x, got.point_y);
    end else begin
      want = point_expect_q.pop_front();
      if (got.touched !== want.touched || got.point_x !== want.point_x ||
          got.point_y !== want.point_y) begin
        errors++;
        if (errors <= 10)
          $display("point mismatch: expected touched=%0d x=%0d y=%0d, got touched=%0d x=%0d y=%0d",
                   want.touched, want.point_x, want.point_y,
                   got.touched, got.point_x, got.point_y);
      end
    end
  endtask

  // request side
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        point_expect_q.push_back(predict_point(sample_data));
        requests++;
      end
      if (!sample_valid || !sample_stall) begin
        if (touch_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          sample_data  <= touch_queue.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst) begin
      point_stall <= 1'b0;
    end else begin
      if (point_valid && !point_stall) check_point(point_data);
      if (hold_req != hold_seen) begin
        hold_seen   <= hold_req;
        hold_left   <= LONG_HOLD;
        point_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        point_stall <= 1'b1;
      end else begin
        point_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points outstanding", cycles, point_expect_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (touch_queue.size() != 0 || sample_valid || point_expect_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DISPLAY_WIDTH:  map_width  = COORD_W'(val);
      REG_DISPLAY_HEIGHT: map_height = COORD_W'(val);
      REG_ROTATION:       map_rot    = rotation_t'(val[1:0]);
      REG_SWAP_AXES:      map_swap   = val[0];
      REG_INVERT_H:       map_inv_h  = val[0];
      REG_INVERT_V:       map_inv_v  = val[0];
      REG_SANITY_LIMIT:   map_limit  = LIMIT_W'(val);
      default: ;
    endcase
  endtask

  task automatic run_setup(int w, int h, int rot, int sw, int ih, int iv, int lim,
                           int sidle, int rstall, int count, bit long_hold);
    int i;
    wait_idle();
    write_reg(REG_DISPLAY_WIDTH, w);
    write_reg(REG_DISPLAY_HEIGHT, h);
    write_reg(REG_ROTATION, rot);
    write_reg(REG_SWAP_AXES, sw);
    write_reg(REG_INVERT_H, ih);
    write_reg(REG_INVERT_V, iv);
    write_reg(REG_SANITY_LIMIT, lim);
    cfg_valid <= 1'b0;
    setups++;
    send_idle_pct = sidle;
    stall_pct     = rstall;
    if (long_hold) hold_req++;
    for (i = 0; i < count; i++) touch_queue.push_back(random_touch());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default setup: 240x240, limit 240, no rotation
    touch_queue.push_back(reading3(0, 10, 10, 0, 20, 20, 0, 30, 30));
    touch_queue.push_back(reading3(255, 0, 0, 0, 5, 5, 0, 9, 9));
    touch_queue.push_back(reading3(1, 10, 20, 2, 30, 5, 3, 20, 40));
    touch_queue.push_back(reading3(1, 100, 100, 1, 50, 50, 1, 240, 10));
    touch_queue.push_back(reading3(1, 239, 239, 0, 0, 0, 0, 0, 0));
    touch_queue.push_back(reading3(5, 4095, 4095, 5, 240, 0, 5, 0, 240));
    touch_queue.push_back(reading3(1, 236, 237, 1, 238, 236, 1, 237, 238));
    touch_queue.push_back(reading3(1, 238, 200, 1, 239, 201, 1, 237, 199));
    touch_queue.push_back(reading3(1, 200, 199, 1, 199, 200, 1, 201, 198));
    touch_queue.push_back(reading3(1, 202, 201, 1, 201, 202, 1, 200, 200));
    touch_queue.push_back(reading3(0, 50, 50, 2, 60, 198, 2, 61, 199));
    touch_queue.push_back(reading3(1, 0, 4095, 1, 4095, 0, 255, 0, 0));
    touch_queue.push_back(reading3(128, 1, 1, 64, 2, 2, 32, 3, 3));
    touch_queue.push_back(reading3(16, 239, 0, 8, 0, 239, 4, 120, 120));
    touch_queue.push_back(reading3(1, 121, 125, 1, 122, 126, 0, 4095, 4095));

    run_setup(240, 320, ROT_90, 0, 0, 0, 4096, 30, 47, 135, 1'b0);
    run_setup(4095, 4095, ROT_180, 1, 1, 0, 4096, 30, 47, 135, 1'b1);
    run_setup(320, 240, ROT_270, 0, 0, 1, 500, 30, 47, 135, 1'b0);
    run_setup(1, 1, ROT_0, 1, 1, 1, 1, 47, 30, 100, 1'b0);
    run_setup(0, 100, ROT_90, 1, 1, 1, 4095, 47, 30, 135, 1'b0);
    run_setup($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 3),
              $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
              $urandom_range(0, 8191), 47, 30, 135, 1'b0);
    run_setup(800, 480, ROT_180, 0, 1, 1, 1000, 0, 0, 135, 1'b0);
    run_setup(4095, 1, ROT_270, 1, 0, 0, 0, 0, 0, 40, 1'b0);

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (point_expect_q.size() != 0) begin
      errors++;
      $display("%0d expected points never arrived", point_expect_q.size());
    end
    $display("%0d touch requests over %0d mapping setups, %0d points checked (%0d untouched)",
             requests, setups, points_seen, untouched);
    $display("%0d mismatches", errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/tpf_pkg.sv
rtl/core/tpf_median.sv
rtl/core/tpf_map.sv
rtl/core/tpf_lock.sv
rtl/core/touch_point_filter_mapper.sv
bench/tb_top.sv
